// ----- sv/wfs_pkg.sv -----
// ----------------------------------------------------------------------------
// wfs_pkg
// Shared widths, register codes, mode codes and helpers for the wall-following
// PD steering block.
// ----------------------------------------------------------------------------
package wfs_pkg;

  // field widths
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned GAIN_W  = 12;
  localparam int unsigned BASE_W  = 11;
  localparam int unsigned SPEED_W = 12;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned PERR_W  = 17;
  localparam int unsigned DERR_W  = 18;
  localparam int unsigned ERR_W   = 32;
  localparam int unsigned CLMP_W  = 16;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDAT_W  = 16;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_WALL_SETPOINT = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_WALL_CLIP     = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_GAIN_P        = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_GAIN_D        = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_STOP_DISTANCE = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_BASE_SPEED    = 3'd5;

  // configuration reset values
  localparam logic [DIST_W-1:0] RST_WALL_SETPOINT = 16'd192;
  localparam logic [DIST_W-1:0] RST_WALL_CLIP     = 16'd1120;
  localparam logic [GAIN_W-1:0] RST_GAIN_P        = 12'd256;
  localparam logic [GAIN_W-1:0] RST_GAIN_D        = 12'd169;
  localparam logic [DIST_W-1:0] RST_STOP_DISTANCE = 16'd128;
  localparam logic [BASE_W-1:0] RST_BASE_SPEED    = 11'd768;

  // drive mode codes
  localparam logic [MODE_W-1:0] MODE_REVERSE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TURN    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DAMPED  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FOLLOW  = 2'd3;

  // corner thresholds, Q12.4
  localparam logic [DIST_W-1:0] LEFT_NEAR     = 16'd480;
  localparam logic [DIST_W-1:0] FL_ENTRY      = 16'd224;
  localparam logic [DIST_W-1:0] FR_ENTRY      = 16'd288;
  localparam logic [DIST_W-1:0] FL_CONTINUE   = 16'd432;
  localparam logic [DIST_W-1:0] FR_CONTINUE   = 16'd576;

  // fixed wheel commands, Q8
  localparam logic signed [SPEED_W-1:0] SPEED_REVERSE    = -12'sd1536;
  localparam logic signed [SPEED_W-1:0] SPEED_TURN_LEFT  = 12'sd1536;
  localparam logic signed [SPEED_W-1:0] SPEED_TURN_RIGHT = -12'sd768;

  // steering clamps, Q.12
  localparam logic signed [ERR_W-1:0] ERR_LO_LEFT  = -32'sd12288;
  localparam logic signed [ERR_W-1:0] ERR_HI_LEFT  = 32'sd24576;
  localparam logic signed [ERR_W-1:0] ERR_LO_RIGHT = -32'sd24576;
  localparam logic signed [ERR_W-1:0] ERR_HI_RIGHT = 32'sd12288;

  // division by 104: offset keeps the dividend positive, 24700 = 104 * 237 + 52
  localparam logic signed [17:0] DIV_OFFSET  = 18'sd24700;
  localparam logic        [10:0] DIV_BIAS_Q  = 11'd237;
  localparam logic        [16:0] DIV13_RECIP = 17'd80660;

  typedef struct packed {
    logic [DIST_W-1:0] wall_setpoint;
    logic [DIST_W-1:0] wall_clip;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_d;
    logic [DIST_W-1:0] stop_distance;
    logic [BASE_W-1:0] base_speed;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic [MODE_W-1:0]       mode;
  } pd_word_t;

  // round(num / 104), half toward +infinity, for num within a steering clamp
  function automatic logic signed [SPEED_W-1:0] div104_round(
    input logic signed [CLMP_W-1:0] num
  );
    logic signed [17:0] ys;
    logic [13:0]        z;
    logic [30:0]        p;
    logic [10:0]        q;
    ys = 18'(num) + DIV_OFFSET;
    z  = ys[16:3];
    p  = 31'(z) * 31'(DIV13_RECIP);
    q  = p[30:20] - DIV_BIAS_Q;
    // quotient is signed after the bias comes off
    return signed'({q[10], q});
  endfunction

  // saturate a wheel sum to the speed range
  function automatic logic signed [SPEED_W-1:0] sat_speed(
    input logic signed [13:0] v
  );
    logic signed [SPEED_W-1:0] r;
    if (v > 14'sd2047) begin
      r = 12'sd2047;
    end else if (v < -14'sd2048) begin
      r = -12'sd2048;
    end else begin
      r = v[SPEED_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/wfs_if.sv -----
// ----------------------------------------------------------------------------
// wfs_if
// Valid/ready channels for sensor words and wheel command words.
// ----------------------------------------------------------------------------
interface wfs_in_if;
  import wfs_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] left_dist;
  logic [DIST_W-1:0] front_left_dist;
  logic [DIST_W-1:0] front_right_dist;

  modport source (
    output valid, left_dist, front_left_dist, front_right_dist,
    input  ready
  );
  modport sink (
    input  valid, left_dist, front_left_dist, front_right_dist,
    output ready
  );
endinterface

interface wfs_out_if;
  import wfs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] left_speed;
  logic signed [SPEED_W-1:0] right_speed;
  logic [MODE_W-1:0]         drive_mode;

  modport source (
    output valid, left_speed, right_speed, drive_mode,
    input  ready
  );
  modport sink (
    input  valid, left_speed, right_speed, drive_mode,
    output ready
  );
endinterface

// ----- sv/wfs_pd_stage.sv -----
// ----------------------------------------------------------------------------
// wfs_pd_stage
// Input register, PD error, corner and reverse decisions, error and turn
// latch state.
// ----------------------------------------------------------------------------
module wfs_pd_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wfs_pkg::cfg_t       cfg_i,
  wfs_in_if.sink              in_i,
  output wfs_pkg::pd_word_t   word_o,
  output logic                word_valid_o,
  input  logic                word_ready_i
);
  import wfs_pkg::*;

  logic                     a_valid_q;
  logic [DIST_W-1:0]        left_q, fl_q, fr_q;
  logic signed [PERR_W-1:0] prev_q;
  logic                     latch_q, latch_d;

  logic [DIST_W-1:0]        lw;
  logic signed [PERR_W-1:0] perror;
  logic signed [DERR_W-1:0] derror;
  logic signed [29:0]       prod_p;
  logic signed [30:0]       prod_d;
  logic                     rev, entry, cont, turn, has_result;
  logic                     a_leave, in_acc;

  // handshake
  assign a_leave    = a_valid_q && (!has_result || word_ready_i);
  assign in_i.ready = !a_valid_q || a_leave;
  assign in_acc     = in_i.valid && in_i.ready;

  // clipped left distance and PD error
  assign lw     = (left_q > cfg_i.wall_clip) ? cfg_i.wall_clip : left_q;
  assign perror = signed'({1'b0, lw}) - signed'({1'b0, cfg_i.wall_setpoint});
  assign derror = DERR_W'(perror) - DERR_W'(prev_q);
  assign prod_p = signed'({1'b0, cfg_i.gain_p}) * perror;
  assign prod_d = signed'({1'b0, cfg_i.gain_d}) * derror;

  // reverse and corner tests
  assign rev   = (fl_q < cfg_i.stop_distance) || (fr_q < cfg_i.stop_distance);
  assign entry = (fl_q < FL_ENTRY) && (lw < LEFT_NEAR)
              && ((fr_q < FR_ENTRY) || ({2'b00, fr_q} > {fl_q, 2'b00}));
  assign cont  = (fl_q < FL_CONTINUE) && (lw < LEFT_NEAR)
              && ((fr_q < FR_CONTINUE) || ({1'b0, fr_q} > {fl_q, 1'b0}));
  assign turn  = entry || latch_q;
  assign has_result = rev || !turn || cont;

  // word to the drive stage
  always_comb begin
    word_o.err = ERR_W'(prod_p) - ERR_W'(prod_d);
    priority if (rev) begin
      word_o.mode = MODE_REVERSE;
    end else if (turn) begin
      word_o.mode = MODE_TURN;
    end else if (derror > 18'sd0) begin
      word_o.mode = MODE_DAMPED;
    end else begin
      word_o.mode = MODE_FOLLOW;
    end
  end
  assign word_valid_o = a_valid_q && has_result;

  // turn latch update
  always_comb begin
    latch_d = latch_q;
    if (!rev && turn) begin
      latch_d = cont;
    end
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      prev_q    <= '0;
      latch_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        a_valid_q <= 1'b1;
      end else if (a_leave) begin
        a_valid_q <= 1'b0;
      end
      if (a_leave) begin
        prev_q  <= perror;
        latch_q <= latch_d;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      left_q <= in_i.left_dist;
      fl_q   <= in_i.front_left_dist;
      fr_q   <= in_i.front_right_dist;
    end
  end

endmodule

// ----- sv/wfs_drive_stage.sv -----
// ----------------------------------------------------------------------------
// wfs_drive_stage
// Error register, per-wheel clamp, scaling and rounding, cruise offset and
// saturation, output register.
// ----------------------------------------------------------------------------
module wfs_drive_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [wfs_pkg::BASE_W-1:0] base_speed_i,
  input  wfs_pkg::pd_word_t   word_i,
  input  logic                word_valid_i,
  output logic                word_ready_o,
  wfs_out_if.source           out_o
);
  import wfs_pkg::*;

  logic                      b_valid_q;
  pd_word_t                  b_word_q;
  logic                      out_valid_q;
  logic signed [SPEED_W-1:0] ls_q, rs_q;
  logic [MODE_W-1:0]         mode_q;

  logic                      adv_out;
  logic signed [CLMP_W-1:0]  lc, rc;
  logic signed [16:0]        lt, rt, rt_up;
  logic signed [SPEED_W-1:0] l8, r8, ls_d, rs_d;
  logic signed [13:0]        base_s;

  // handshake
  assign adv_out      = !out_valid_q || out_o.ready;
  assign word_ready_o = !b_valid_q || adv_out;

  // per-wheel clamp
  always_comb begin
    if (b_word_q.err < ERR_LO_LEFT) begin
      lc = CLMP_W'(ERR_LO_LEFT);
    end else if (b_word_q.err > ERR_HI_LEFT) begin
      lc = CLMP_W'(ERR_HI_LEFT);
    end else begin
      lc = CLMP_W'(b_word_q.err);
    end
    if (b_word_q.err < ERR_LO_RIGHT) begin
      rc = CLMP_W'(ERR_LO_RIGHT);
    end else if (b_word_q.err > ERR_HI_RIGHT) begin
      rc = CLMP_W'(ERR_HI_RIGHT);
    end else begin
      rc = CLMP_W'(b_word_q.err);
    end
  end

  // scale to Q8 with rounding, damped path divides by 6.5 as well
  assign lt     = 17'(lc) + 17'sd8;
  assign rt     = 17'(rc) + 17'sd8;
  assign rt_up  = rt + 17'sd15;
  assign base_s = signed'({3'b000, base_speed_i});

  // below -4.0, i.e. -1024 in Q8, the right wheel quotient rounds toward zero
  always_comb begin
    if (b_word_q.mode == MODE_DAMPED) begin
      l8 = div104_round(lc);
      r8 = div104_round(rc);
    end else begin
      l8 = lt[15:4];
      r8 = (rt < -17'sd16384) ? rt_up[15:4] : rt[15:4];
    end
  end

  // wheel commands by mode
  always_comb begin
    unique case (b_word_q.mode)
      MODE_REVERSE: begin
        ls_d = SPEED_REVERSE;
        rs_d = SPEED_REVERSE;
      end
      MODE_TURN: begin
        ls_d = SPEED_TURN_LEFT;
        rs_d = SPEED_TURN_RIGHT;
      end
      default: begin
        ls_d = sat_speed(base_s - 14'(l8));
        rs_d = sat_speed(base_s + 14'(r8));
      end
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (word_valid_i && word_ready_o) begin
        b_valid_q <= 1'b1;
      end else if (adv_out) begin
        b_valid_q <= 1'b0;
      end
      if (adv_out) begin
        out_valid_q <= b_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (word_valid_i && word_ready_o) begin
      b_word_q <= word_i;
    end
    if (adv_out && b_valid_q) begin
      ls_q   <= ls_d;
      rs_q   <= rs_d;
      mode_q <= b_word_q.mode;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.left_speed  = ls_q;
  assign out_o.right_speed = rs_q;
  assign out_o.drive_mode  = mode_q;

endmodule

// ----- sv/wall_follow_pd_steering.sv -----
// ----------------------------------------------------------------------------
// wall_follow_pd_steering
// Wall-following PD steering: sensor words in, wheel command words out.
// ----------------------------------------------------------------------------
// Takes one sensor word per clock while the output accepts commands, and
// presents its wheel command on the output after the input register, error
// register and output register;
// a word that ends a right turn gives no command and is dropped in the first
// stage. Throughput is one word per cycle while the output is not stalled,
// set by the first stage, which holds the previous error and the turn latch
// and updates them as each word leaves it. Write the configuration registers
// only while no word is in flight; indexes past the last register are ignored.
module wall_follow_pd_steering (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [wfs_pkg::CIDX_W-1:0] cfg_index_i,
  input  logic [wfs_pkg::CDAT_W-1:0] cfg_data_i,
  wfs_in_if.sink                     in_i,
  wfs_out_if.source                  out_o
);
  import wfs_pkg::*;

  cfg_t     cfg_q;
  pd_word_t word;
  logic     word_valid, word_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wall_setpoint <= RST_WALL_SETPOINT;
      cfg_q.wall_clip     <= RST_WALL_CLIP;
      cfg_q.gain_p        <= RST_GAIN_P;
      cfg_q.gain_d        <= RST_GAIN_D;
      cfg_q.stop_distance <= RST_STOP_DISTANCE;
      cfg_q.base_speed    <= RST_BASE_SPEED;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WALL_SETPOINT: cfg_q.wall_setpoint <= cfg_data_i;
        CFG_WALL_CLIP:     cfg_q.wall_clip     <= cfg_data_i;
        CFG_GAIN_P:        cfg_q.gain_p        <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_D:        cfg_q.gain_d        <= cfg_data_i[GAIN_W-1:0];
        CFG_STOP_DISTANCE: cfg_q.stop_distance <= cfg_data_i;
        CFG_BASE_SPEED:    cfg_q.base_speed    <= cfg_data_i[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // error and decision stage
  wfs_pd_stage u_pd_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .word_o       (word),
    .word_valid_o (word_valid),
    .word_ready_i (word_ready)
  );

  // wheel command stage
  wfs_drive_stage u_drive_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .base_speed_i (cfg_q.base_speed),
    .word_i       (word),
    .word_valid_i (word_valid),
    .word_ready_o (word_ready),
    .out_o        (out_o)
  );

endmodule
